>>> rtl/pgd_pkg.sv
// Shared types, constants and command codes for the Poincare distance block.
`default_nettype none
package pgd_pkg;

    localparam int ELEM_BITS = 16;
    localparam int CURV_BITS = 16;
    localparam int ACC_BITS  = 42;
    localparam int DIST_BITS = 24;

    localparam int LOG_ITERS  = 30;
    localparam int ROOT_ITERS = 32;
    localparam int DIV_ITERS  = 77;
    localparam int CNT_BITS   = 7;

    localparam logic [CURV_BITS-1:0] CURV_RESET = 16'd4096;
    localparam logic [29:0]          LN2_Q30    = 30'd744261118;
    localparam logic [35:0]          LOG_BIAS   = 36'd32212254720;
    localparam logic [63:0]          ONE_Q30    = 64'd1073741824;
    localparam logic [DIST_BITS-1:0] DIST_MAX   = 24'hFFFFFF;

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] first_elem;
        logic signed [ELEM_BITS-1:0] second_elem;
        logic                        last_elem;
    } pgd_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 saturated;
    } pgd_out_t;

    typedef enum logic [1:0] {
        SH_11,
        SH_12,
        SH_30
    } mul_shift_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_ACCUM,
        CMD_MUL_T1,
        CMD_T1_MUL_T2,
        CMD_T2_MUL_NUM,
        CMD_NUM_MUL_DEN,
        CMD_DEN_SET,
        CMD_LOG_LOAD_SUM,
        CMD_LOG_NORM,
        CMD_LOG_ITER,
        CMD_LOG_LOAD_DEN,
        CMD_MUL_L2,
        CMD_DIV_LOAD_R,
        CMD_DIV_STEP,
        CMD_MUL_V,
        CMD_SQRT_LOAD_V,
        CMD_SQRT_NORM,
        CMD_SQRT_START,
        CMD_SQRT_STEP,
        CMD_LOG_LOAD_Y,
        CMD_MUL_LY,
        CMD_SQRT_LOAD_CV,
        CMD_DIV_LOAD_D,
        CMD_OUT_WRITE
    } pgd_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic big_ratio;
        logic log_top;
        logic root_norm_done;
        logic out_free;
    } pgd_status_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_T1_GO,
        ST_T1_WAIT,
        ST_T2_GO,
        ST_T2_WAIT,
        ST_NUM_GO,
        ST_NUM_WAIT,
        ST_DEN_GO,
        ST_DEN_WAIT,
        ST_DEN_SET,
        ST_BRANCH,
        ST_LA_NORM,
        ST_LA_ITER,
        ST_LB_LOAD,
        ST_LB_NORM,
        ST_LB_ITER,
        ST_L2_GO,
        ST_L2_WAIT,
        ST_DIV_R,
        ST_V_GO,
        ST_V_WAIT,
        ST_SQ_LOAD,
        ST_SQ_NORM,
        ST_SQ_SHIFT,
        ST_SQ_ITER,
        ST_Y_LOAD,
        ST_LC_NORM,
        ST_LC_ITER,
        ST_LY_GO,
        ST_LY_WAIT,
        ST_S_LOAD,
        ST_S_ITER,
        ST_D_LOAD,
        ST_D_DIV,
        ST_OUT
    } pgd_state_t;

endpackage
`default_nettype wire

>>> rtl/pgd_mul.sv
// Multi-cycle 64x64 multiplier built from 32x32 partial products, with shift and saturation.
`default_nettype none
module pgd_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    input  pgd_pkg::mul_shift_t sh,
    output logic [63:0]        res,
    output logic               done
);
    import pgd_pkg::*;

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    mul_shift_t   sh_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   poff_reg;
    logic [127:0] acc_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [127:0] prod_shifted;

    assign a_half = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = step_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (poff_reg)
            2'd0:    prod_shifted = {64'b0, prod_reg};
            2'd1:    prod_shifted = {32'b0, prod_reg, 32'b0};
            default: prod_shifted = {prod_reg, 64'b0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 3'd4);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            sh_reg  <= sh;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd4)
            begin
                prod_reg <= a_half * b_half;
                poff_reg <= {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_reg + prod_shifted;
            end
        end
    end

    always_comb
    begin
        case (sh_reg)
            SH_11:   res = (acc_reg[127:75] != '0) ? '1 : acc_reg[74:11];
            SH_12:   res = (acc_reg[127:76] != '0) ? '1 : acc_reg[75:12];
            default: res = (acc_reg[127:94] != '0) ? '1 : acc_reg[93:30];
        endcase
    end

    assign done = done_reg;

endmodule
`default_nettype wire

>>> rtl/pgd_dp.sv
// Datapath: accumulators, curvature register, log, root and divide iterations, output register.
`default_nettype none
module pgd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pgd_pkg::pgd_cmd_t    cmd,
    output pgd_pkg::pgd_status_t status,
    input  pgd_pkg::pgd_in_t     in_data,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output pgd_pkg::pgd_out_t    out_data
);
    import pgd_pkg::*;

    logic [CURV_BITS-1:0] curv_reg;
    logic [CURV_BITS-1:0] cv;
    logic [ACC_BITS-1:0]  acc_d_reg;
    logic [ACC_BITS-1:0]  acc_a_reg;
    logic [ACC_BITS-1:0]  acc_b_reg;
    logic                 out_valid_reg;
    pgd_out_t             out_reg;

    logic signed [47:0] t1_reg;
    logic signed [47:0] t2_reg;
    logic [46:0]        num_reg;
    logic [63:0]        den_reg;
    logic [35:0]        lnum_reg;
    logic [39:0]        acosh_reg;
    logic [63:0]        lx_reg;
    logic [5:0]         lp_reg;
    logic [30:0]        lm_reg;
    logic [29:0]        lfrac_reg;
    logic [76:0]        dvd_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        dsr_reg;
    logic [63:0]        quo_reg;
    logic [63:0]        sx_reg;
    logic [63:0]        sres_reg;
    logic [63:0]        sbit_reg;
    logic [4:0]         se_reg;
    logic [64:0]        lim_reg;

    logic signed [ELEM_BITS:0] diff;
    logic [ELEM_BITS-1:0]      mag_a;
    logic [ELEM_BITS-1:0]      mag_b;
    logic [ELEM_BITS-1:0]      mag_d;
    logic [2*ELEM_BITS-1:0]    sq_a;
    logic [2*ELEM_BITS-1:0]    sq_b;
    logic [2*ELEM_BITS-1:0]    sq_d;

    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    mul_shift_t  mul_sh;
    logic [63:0] mul_res;
    logic        mul_done;

    logic [46:0] t1_mag;
    logic [46:0] t2_mag;
    logic        same_sign;
    logic [35:0] log_val;
    logic [36:0] l2;
    logic [35:0] ly;
    logic [63:0] root_out;
    logic [61:0] lsq;
    logic [64:0] rem2;
    logic        div_ge;
    logic [64:0] rem_sub;
    logic [63:0] trial;
    logic        root_ge;
    logic        root_grow;

    function automatic logic [ACC_BITS-1:0] sat_acc(input logic [ACC_BITS-1:0] acc,
                                                    input logic [2*ELEM_BITS-1:0] sq);
        logic [ACC_BITS:0] sum;
        sum = {1'b0, acc} + (ACC_BITS+1)'(sq);
        return sum[ACC_BITS] ? '1 : sum[ACC_BITS-1:0];
    endfunction

    assign cv = (curv_reg == '0) ? CURV_BITS'(1) : curv_reg;

    assign diff  = {in_data.first_elem[ELEM_BITS-1], in_data.first_elem}
                 - {in_data.second_elem[ELEM_BITS-1], in_data.second_elem};
    assign mag_a = in_data.first_elem[ELEM_BITS-1] ? ELEM_BITS'(-in_data.first_elem)
                                                   : ELEM_BITS'(in_data.first_elem);
    assign mag_b = in_data.second_elem[ELEM_BITS-1] ? ELEM_BITS'(-in_data.second_elem)
                                                    : ELEM_BITS'(in_data.second_elem);
    assign mag_d = diff[ELEM_BITS] ? ELEM_BITS'(-diff) : ELEM_BITS'(diff);
    assign sq_a  = mag_a * mag_a;
    assign sq_b  = mag_b * mag_b;
    assign sq_d  = mag_d * mag_d;

    assign t1_mag    = t1_reg[47] ? 47'(-t1_reg) : t1_reg[46:0];
    assign t2_mag    = t2_reg[47] ? 47'(-t2_reg) : t2_reg[46:0];
    assign same_sign = (!t1_reg[47] && t1_reg != '0 && !t2_reg[47] && t2_reg != '0)
                    || (t1_reg[47] && t2_reg[47]);

    assign log_val  = {lp_reg, lfrac_reg};
    assign l2       = 37'(ONE_Q30) + ((lnum_reg >= log_val) ? {1'b0, lnum_reg - log_val} : 37'd0);
    assign ly       = (log_val >= LOG_BIAS) ? log_val - LOG_BIAS : 36'd0;
    assign root_out = sres_reg << ((5'd30 - se_reg) >> 1);
    assign lsq      = lm_reg * lm_reg;

    assign rem2    = {rem_reg, dvd_reg[76]};
    assign div_ge  = rem2 >= {1'b0, dsr_reg};
    assign rem_sub = rem2 - {1'b0, dsr_reg};
    assign trial   = sres_reg + sbit_reg;
    assign root_ge = sx_reg >= trial;
    assign root_grow = (se_reg != 5'd0) && ({1'b0, sx_reg} >= lim_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_start = 1'b1;
        mul_a     = 64'(cv);
        mul_b     = 64'(acc_a_reg);
        mul_sh    = SH_12;
        unique case (cmd)
            CMD_MUL_T1:      mul_b = 64'(acc_a_reg);
            CMD_T1_MUL_T2:   mul_b = 64'(acc_b_reg);
            CMD_T2_MUL_NUM:
            begin
                mul_b  = 64'(acc_d_reg);
                mul_sh = SH_11;
            end
            CMD_NUM_MUL_DEN:
            begin
                mul_a  = 64'(t1_mag);
                mul_b  = 64'(t2_mag);
                mul_sh = SH_30;
            end
            CMD_MUL_L2:
            begin
                mul_a  = 64'(l2);
                mul_b  = 64'(LN2_Q30);
                mul_sh = SH_30;
            end
            CMD_MUL_V:
            begin
                mul_a  = quo_reg;
                mul_b  = quo_reg + (ONE_Q30 << 1);
                mul_sh = SH_30;
            end
            CMD_MUL_LY:
            begin
                mul_a  = 64'(ly);
                mul_b  = 64'(LN2_Q30);
                mul_sh = SH_30;
            end
            default:         mul_start = 1'b0;
        endcase
    end

    pgd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .res   (mul_res),
        .done  (mul_done)
    );

    // Control state: curvature, accumulators and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curv_reg      <= CURV_RESET;
            acc_d_reg     <= '0;
            acc_a_reg     <= '0;
            acc_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                curv_reg <= cfg_wr_data;
            end
            if (cmd == CMD_ACCUM)
            begin
                acc_d_reg <= sat_acc(acc_d_reg, sq_d);
                acc_a_reg <= sat_acc(acc_a_reg, sq_a);
                acc_b_reg <= sat_acc(acc_b_reg, sq_b);
            end
            else if (cmd == CMD_OUT_WRITE)
            begin
                acc_d_reg <= '0;
                acc_a_reg <= '0;
                acc_b_reg <= '0;
            end
            if (cmd == CMD_OUT_WRITE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_T1_MUL_T2:   t1_reg <= 48'(ONE_Q30) - {2'b0, mul_res[45:0]};
            CMD_T2_MUL_NUM:  t2_reg <= 48'(ONE_Q30) - {2'b0, mul_res[45:0]};
            CMD_NUM_MUL_DEN: num_reg <= mul_res[46:0];
            CMD_DEN_SET:     den_reg <= (same_sign && mul_res != '0) ? mul_res : 64'd1;
            CMD_LOG_LOAD_SUM:
            begin
                lx_reg    <= 64'(num_reg) + den_reg;
                lp_reg    <= 6'd63;
                lfrac_reg <= '0;
            end
            CMD_LOG_LOAD_DEN:
            begin
                lnum_reg  <= log_val;
                lx_reg    <= den_reg;
                lp_reg    <= 6'd63;
                lfrac_reg <= '0;
            end
            CMD_LOG_LOAD_Y:
            begin
                lx_reg    <= ONE_Q30 + quo_reg + root_out;
                lp_reg    <= 6'd63;
                lfrac_reg <= '0;
            end
            CMD_LOG_NORM:
            begin
                if (lx_reg[63])
                begin
                    lm_reg <= lx_reg[63:33];
                end
                else
                begin
                    lx_reg <= {lx_reg[62:0], 1'b0};
                    lp_reg <= lp_reg - 6'd1;
                end
            end
            CMD_LOG_ITER:
            begin
                if (lsq[61])
                begin
                    lm_reg    <= lsq[61:31];
                    lfrac_reg <= {lfrac_reg[28:0], 1'b1};
                end
                else
                begin
                    lm_reg    <= lsq[60:30];
                    lfrac_reg <= {lfrac_reg[28:0], 1'b0};
                end
            end
            CMD_DIV_LOAD_R:
            begin
                dvd_reg <= {num_reg, 30'b0};
                dsr_reg <= den_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            CMD_DIV_LOAD_D:
            begin
                dvd_reg <= 77'({acosh_reg, 8'b0});
                dsr_reg <= sres_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[75:0], 1'b0};
                rem_reg <= div_ge ? rem_sub[63:0] : rem2[63:0];
                quo_reg <= {quo_reg[62:0], div_ge};
            end
            CMD_SQRT_LOAD_V:
            begin
                sx_reg  <= mul_res;
                se_reg  <= 5'd30;
                lim_reg <= 65'd1 << 34;
            end
            CMD_SQRT_NORM:
            begin
                if (root_grow)
                begin
                    se_reg  <= se_reg - 5'd2;
                    lim_reg <= lim_reg << 2;
                end
            end
            CMD_SQRT_START:
            begin
                sx_reg   <= sx_reg << se_reg;
                sres_reg <= '0;
                sbit_reg <= 64'd1 << 62;
            end
            CMD_SQRT_LOAD_CV:
            begin
                acosh_reg <= mul_res[39:0];
                sx_reg    <= {16'b0, cv, 32'b0};
                sres_reg  <= '0;
                sbit_reg  <= 64'd1 << 62;
            end
            CMD_SQRT_STEP:
            begin
                if (root_ge)
                begin
                    sx_reg   <= sx_reg - trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            CMD_OUT_WRITE:
            begin
                out_reg.distance  <= (quo_reg > 64'(DIST_MAX)) ? DIST_MAX : quo_reg[23:0];
                out_reg.saturated <= quo_reg > 64'(DIST_MAX);
            end
            default:
            begin
            end
        endcase
    end

    assign status.mul_done       = mul_done;
    assign status.big_ratio      = 64'(num_reg[46:16]) >= den_reg;
    assign status.log_top        = lx_reg[63];
    assign status.root_norm_done = !root_grow;
    assign status.out_free       = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

>>> rtl/pgd_ctrl.sv
// Controller state machine that sequences the datapath through one distance evaluation.
`default_nettype none
module pgd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  pgd_pkg::pgd_status_t status,
    output pgd_pkg::pgd_cmd_t    cmd
);
    import pgd_pkg::*;

    pgd_state_t          state_reg;
    pgd_state_t          state_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = CMD_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = CMD_ACCUM;
                    if (in_last)
                    begin
                        state_next = ST_T1_GO;
                    end
                end
            end
            ST_T1_GO:
            begin
                cmd        = CMD_MUL_T1;
                state_next = ST_T1_WAIT;
            end
            ST_T1_WAIT:  if (status.mul_done) state_next = ST_T2_GO;
            ST_T2_GO:
            begin
                cmd        = CMD_T1_MUL_T2;
                state_next = ST_T2_WAIT;
            end
            ST_T2_WAIT:  if (status.mul_done) state_next = ST_NUM_GO;
            ST_NUM_GO:
            begin
                cmd        = CMD_T2_MUL_NUM;
                state_next = ST_NUM_WAIT;
            end
            ST_NUM_WAIT: if (status.mul_done) state_next = ST_DEN_GO;
            ST_DEN_GO:
            begin
                cmd        = CMD_NUM_MUL_DEN;
                state_next = ST_DEN_WAIT;
            end
            ST_DEN_WAIT: if (status.mul_done) state_next = ST_DEN_SET;
            ST_DEN_SET:
            begin
                cmd        = CMD_DEN_SET;
                state_next = ST_BRANCH;
            end
            ST_BRANCH:
            begin
                cnt_next = '0;
                if (status.big_ratio)
                begin
                    cmd        = CMD_LOG_LOAD_SUM;
                    state_next = ST_LA_NORM;
                end
                else
                begin
                    cmd        = CMD_DIV_LOAD_R;
                    state_next = ST_DIV_R;
                end
            end
            ST_LA_NORM, ST_LB_NORM, ST_LC_NORM:
            begin
                cmd = CMD_LOG_NORM;
                if (status.log_top)
                begin
                    cnt_next = '0;
                    unique case (state_reg)
                        ST_LA_NORM: state_next = ST_LA_ITER;
                        ST_LB_NORM: state_next = ST_LB_ITER;
                        default:    state_next = ST_LC_ITER;
                    endcase
                end
            end
            ST_LA_ITER, ST_LB_ITER, ST_LC_ITER:
            begin
                cmd      = CMD_LOG_ITER;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(LOG_ITERS - 1))
                begin
                    unique case (state_reg)
                        ST_LA_ITER: state_next = ST_LB_LOAD;
                        ST_LB_ITER: state_next = ST_L2_GO;
                        default:    state_next = ST_LY_GO;
                    endcase
                end
            end
            ST_LB_LOAD:
            begin
                cmd        = CMD_LOG_LOAD_DEN;
                state_next = ST_LB_NORM;
            end
            ST_L2_GO:
            begin
                cmd        = CMD_MUL_L2;
                state_next = ST_L2_WAIT;
            end
            ST_L2_WAIT:  if (status.mul_done) state_next = ST_S_LOAD;
            ST_DIV_R, ST_D_DIV:
            begin
                cmd      = CMD_DIV_STEP;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(DIV_ITERS - 1))
                begin
                    state_next = (state_reg == ST_DIV_R) ? ST_V_GO : ST_OUT;
                end
            end
            ST_V_GO:
            begin
                cmd        = CMD_MUL_V;
                state_next = ST_V_WAIT;
            end
            ST_V_WAIT:   if (status.mul_done) state_next = ST_SQ_LOAD;
            ST_SQ_LOAD:
            begin
                cmd        = CMD_SQRT_LOAD_V;
                state_next = ST_SQ_NORM;
            end
            ST_SQ_NORM:
            begin
                cmd = CMD_SQRT_NORM;
                if (status.root_norm_done)
                begin
                    state_next = ST_SQ_SHIFT;
                end
            end
            ST_SQ_SHIFT:
            begin
                cmd        = CMD_SQRT_START;
                cnt_next   = '0;
                state_next = ST_SQ_ITER;
            end
            ST_SQ_ITER, ST_S_ITER:
            begin
                cmd      = CMD_SQRT_STEP;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(ROOT_ITERS - 1))
                begin
                    state_next = (state_reg == ST_SQ_ITER) ? ST_Y_LOAD : ST_D_LOAD;
                end
            end
            ST_Y_LOAD:
            begin
                cmd        = CMD_LOG_LOAD_Y;
                state_next = ST_LC_NORM;
            end
            ST_LY_GO:
            begin
                cmd        = CMD_MUL_LY;
                state_next = ST_LY_WAIT;
            end
            ST_LY_WAIT:  if (status.mul_done) state_next = ST_S_LOAD;
            ST_S_LOAD:
            begin
                cmd        = CMD_SQRT_LOAD_CV;
                cnt_next   = '0;
                state_next = ST_S_ITER;
            end
            ST_D_LOAD:
            begin
                cmd        = CMD_DIV_LOAD_D;
                cnt_next   = '0;
                state_next = ST_D_DIV;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd        = CMD_OUT_WRITE;
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/poincare_geodesic_distance.sv
// Throughput: one coordinate pair per cycle while idle, then the block is busy for the final
// evaluation, whose length is set by the serial log2 (up to 64 normalize + 30 square steps per
// log), the 32-step square roots, the 77-step restoring divides and the shared multiplier.
// Reset: asynchronous active low; clears the sums, sets curvature to 1.0, empties the output.
`default_nettype none
module poincare_geodesic_distance (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pgd_pkg::pgd_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pgd_pkg::pgd_out_t out_data,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);
    import pgd_pkg::*;

    // The controller issues one datapath command per cycle and reacts to the status flags.
    // While idle it accepts coordinate transfers, even with a result still waiting in the
    // output register; a last coordinate starts the evaluation, which ends by writing the
    // result as soon as the output register is free.
    pgd_cmd_t    cmd;
    pgd_status_t status;

    pgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_elem),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the three saturating sums, the curvature register, the shared
    // multiplier and the iterative log2, square root and divide units.
    pgd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the Poincare-ball geodesic distance block.
`timescale 1ns / 1ps
module testbench;
    import pgd_pkg::*;

    localparam int GAP_MAX     = 17;
    localparam int DRAIN_WAIT  = 500;    // Covers the longest final evaluation.
    localparam int LONG_HOLD   = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam logic [63:0] SUM_MAX = (64'd1 << 42) - 64'd1;
    localparam logic [63:0] ONE_FIX = 64'd1 << 30;
    localparam logic [63:0] LN2_FIX = 64'd744261118;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pgd_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    pgd_out_t    out_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    poincare_geodesic_distance i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Coordinate pairs waiting to be offered, and distances waiting to come out.
    pgd_in_t  coord_queue[$];
    pgd_out_t distance_queue[$];

    // Predictor state: the three running sums and the curvature register copy.
    logic [63:0] diff_sum;
    logic [63:0] norm_a_sum;
    logic [63:0] norm_b_sum;
    logic [15:0] curv_copy;

    int  error_count;
    bit  idle_on;        // When clear, neither side inserts gaps.
    bit  hold_go;        // Asks the receiver for one long hold-off.
    bit  in_took;
    bit  out_took;
    int  stall_cycles;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point helpers of the predictor.
    // ---------------------------------------------------------------------

    // floor(a*b / 2^sh), saturated to 64 bits.
    function automatic logic [63:0] mul_floor(input logic [63:0] a, input logic [63:0] b,
                                              input int sh);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if ((prod >> (64 + sh)) != 0)
            return '1;
        return 64'(prod >> sh);
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Base-2 logarithm of an integer, returned with 30 fraction bits.
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int unsigned p;
        logic [63:0] mnt;
        logic [63:0] res;
        p = 0;
        if (x == 0)
            return 0;
        while (p < 63 && (x >> (p + 1)) != 0)
            p++;
        mnt = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        res = 64'(p) << 30;
        for (int i = 0; i < 30; i++)
        begin
            mnt = (mnt * mnt) >> 30;
            if (mnt >= (ONE_FIX << 1))
            begin
                mnt = mnt >> 1;
                res = res | (64'd1 << (29 - i));
            end
        end
        return res;
    endfunction

    // Square root of a value with 30 fraction bits.
    function automatic logic [63:0] root_fix(input logic [63:0] v);
        int unsigned e;
        e = 30;
        while (e > 0 && (v >> (64 - e)) != 0)
            e -= 2;
        return int_root(v << e) << ((30 - e) / 2);
    endfunction

    function automatic logic [63:0] add_clamped(input logic [63:0] acc, input logic [63:0] v);
        if (v > SUM_MAX || acc > SUM_MAX - v)
            return SUM_MAX;
        return acc + v;
    endfunction

    // Folds one coordinate pair into the sums; on the last one it yields the distance.
    task automatic advance_distance(input pgd_in_t item, output bit has_result,
                                    output pgd_out_t result);
        longint      a, b, df, t1, t2;
        logic [63:0] ua, ub, ud, cv, sq, aq, bq, num, den, acosh_fix, s, dist_val;
        logic [63:0] lnum, lden, l2, q, rem, r, v, y, ly;
        a  = longint'(item.first_elem);
        b  = longint'(item.second_elem);
        df = a - b;
        ua = 64'(a < 0 ? -a : a);
        ub = 64'(b < 0 ? -b : b);
        ud = 64'(df < 0 ? -df : df);
        diff_sum   = add_clamped(diff_sum, ud * ud);
        norm_a_sum = add_clamped(norm_a_sum, ua * ua);
        norm_b_sum = add_clamped(norm_b_sum, ub * ub);
        has_result = 1'b0;
        result     = '0;
        if (!item.last_elem)
            return;

        // A zero register is taken as the smallest curvature.
        cv = (curv_copy != 0) ? 64'(curv_copy) : 64'd1;
        sq = diff_sum;
        aq = norm_a_sum;
        bq = norm_b_sum;
        diff_sum   = 0;
        norm_a_sum = 0;
        norm_b_sum = 0;

        t1 = longint'(ONE_FIX) - longint'((cv * aq) >> 12);
        t2 = longint'(ONE_FIX) - longint'((cv * bq) >> 12);
        if (t1 > 0 && t2 > 0)
            den = (64'(t1) * 64'(t2)) >> 30;
        else if (t1 < 0 && t2 < 0)
            den = mul_floor(64'(-t1), 64'(-t2), 30);
        else
            den = 1;
        if (den < 1)
            den = 1;

        num = (cv * sq) >> 11;

        if ((num >> 16) >= den)
        begin
            // Large ratio: acosh(1+r) is taken as ln(2(1+r)).
            lnum = log2_fix(num + den);
            lden = log2_fix(den);
            l2   = ONE_FIX + ((lnum >= lden) ? lnum - lden : 64'd0);
            acosh_fix = mul_floor(l2, LN2_FIX, 30);
        end
        else
        begin
            q   = num / den;
            rem = num % den;
            for (int i = 0; i < 30; i++)
            begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    q   = q | 64'd1;
                end
            end
            r  = q;
            v  = mul_floor(r, r + (ONE_FIX << 1), 30);
            y  = ONE_FIX + r + root_fix(v);
            ly = log2_fix(y);
            ly = (ly >= (64'd30 << 30)) ? ly - (64'd30 << 30) : 64'd0;
            acosh_fix = mul_floor(ly, LN2_FIX, 30);
        end

        s        = int_root(cv << 32);
        dist_val = (acosh_fix << 8) / s;
        has_result = 1'b1;
        if (dist_val > 64'hFFFFFF)
        begin
            result.distance  = DIST_MAX;
            result.saturated = 1'b1;
        end
        else
        begin
            result.distance  = dist_val[23:0];
            result.saturated = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Sender: takes the next pair from the queue, waits a drawn gap, then
    // holds valid and data until the transfer happens.
    // ---------------------------------------------------------------------
    pgd_in_t next_item;
    bit      have_next;
    int      send_gap;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_took)
            begin
                // Keep offering the same pair.
            end
            else
            begin
                if (!have_next && coord_queue.size() > 0)
                begin
                    next_item = coord_queue.pop_front();
                    have_next = 1'b1;
                    send_gap  = idle_on ? $urandom_range(0, GAP_MAX) : 0;
                end
                if (have_next && send_gap == 0)
                begin
                    in_valid  <= 1'b1;
                    in_data   <= next_item;
                    have_next = 1'b0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (have_next)
                        send_gap--;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: a drawn gap after every result transfer, plus one long
    // hold-off on request, counted here.
    // ---------------------------------------------------------------------
    int recv_gap;
    int hold_left;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (out_took)
                    recv_gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
                else if (recv_gap > 0)
                    recv_gap--;
                out_ready <= (recv_gap == 0);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: predicts on every accepted pair and checks every result.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        bit       has;
        pgd_out_t exp_res;
        pgd_out_t want;
        in_took  = rst_n && in_valid && in_ready;
        out_took = rst_n && out_valid && out_ready;
        if (in_took)
        begin
            advance_distance(in_data, has, exp_res);
            if (has)
                distance_queue.push_back(exp_res);
        end
        if (out_took)
        begin
            if (distance_queue.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(out_data), 64'd0);
            end
            else
            begin
                want = distance_queue.pop_front();
                if (out_data.distance !== want.distance)
                    report_mismatch("distance", 64'(out_data.distance), 64'(want.distance));
                if (out_data.saturated !== want.saturated)
                    report_mismatch("saturated", 64'(out_data.saturated),
                                    64'(want.saturated));
            end
        end
        // Watchdog on cycles without any transfer.
        if (in_took || out_took)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------
    function automatic logic [15:0] rand_coord(input int scale);
        logic [15:0] raw;
        raw = 16'($urandom);
        return 16'($signed(raw) >>> scale);
    endfunction

    task automatic push_pair(input logic [15:0] a, input logic [15:0] b, input bit last);
        pgd_in_t it;
        it.first_elem  = a;
        it.second_elem = b;
        it.last_elem   = last;
        coord_queue.push_back(it);
    endtask

    // One vector pair of the given length; both vectors usually share one magnitude scale.
    task automatic push_vector(input int len, output int used);
        int sa, sb;
        sa = $urandom_range(0, 9);
        sb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : sa;
        for (int i = 0; i < len; i++)
            push_pair(rand_coord(sa), rand_coord(sb), i == len - 1);
        used = len;
    endtask

    task automatic push_random(input int count);
        int done, used, len, pick;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                len = $urandom_range(1, 8);
            else if (pick < 18)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(65, 256);
            if ($urandom_range(0, 15) == 0)
            begin
                // A stray pair with random flag as noise.
                push_pair(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
                used = 1;
            end
            else
            begin
                push_vector(len, used);
            end
            done += used;
        end
    endtask

    // Waits until every pair is sent and every distance has arrived,
    // then lets the block settle.
    task automatic drain_all();
        while (coord_queue.size() > 0 || have_next || in_valid || distance_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_curvature(input logic [15:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        curv_copy = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------
    initial begin
        int used;
        logic [15:0] curv_list[6];
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        rst_n        = 1'b0;
        diff_sum     = 0;
        norm_a_sum   = 0;
        norm_b_sum   = 0;
        curv_copy    = CURV_RESET;
        error_count  = 0;
        idle_on      = 1'b0;
        hold_go      = 1'b0;
        in_took      = 1'b0;
        out_took     = 1'b0;
        stall_cycles = 0;
        have_next    = 1'b0;
        send_gap     = 0;
        recv_gap     = 0;
        hold_left    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs at reset curvature: zero distance, field extremes,
        // norms past the ball edge, and the large-ratio branch.
        push_pair(16'sd0, 16'sd0, 1'b1);
        push_pair(16'sh7FFF, 16'sh8000, 1'b1);
        push_pair(16'sh8000, 16'sh8000, 1'b1);
        push_pair(16'sh8000, 16'sh7FFF, 1'b0);
        push_pair(16'sh7FFF, 16'sh8000, 1'b1);
        push_pair(16'sd1, 16'shFFFF, 1'b1);
        push_pair(16'sh0100, 16'sh0000, 1'b1);
        push_pair(16'sh4000, 16'shC000, 1'b0);
        push_pair(16'sh4000, 16'shC000, 1'b1);
        push_pair(16'sh5A82, 16'sh0000, 1'b0);
        push_pair(16'sh5A81, 16'sh0000, 1'b1);
        push_pair(16'sh7000, 16'sh0001, 1'b1);
        for (int i = 0; i < 4; i++)
            push_pair(16'sh7FFF, 16'sh7FFF, i == 3);
        drain_all();

        // Curvature extremes: zero is taken as the smallest value, and the
        // largest one drives both factors negative.
        write_curvature(16'd0);
        push_pair(16'sh7FFF, 16'sh8000, 1'b1);
        push_pair(16'sh0001, 16'sh0000, 1'b1);
        drain_all();
        write_curvature(16'hFFFF);
        push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        push_pair(16'sh8000, 16'sh7FFF, 1'b1);
        push_pair(16'sh0010, 16'shFFF0, 1'b1);
        drain_all();

        // Accumulator overflow: enough maximal pairs to saturate the difference sum.
        write_curvature(CURV_RESET);
        for (int i = 0; i < 1100; i++)
            push_pair(16'sh8000, 16'sh7FFF, i == 1099);
        drain_all();

        // Long receiver hold-off with back-to-back short vectors, so the
        // block fills up and stops taking coordinates.
        hold_go = 1'b1;
        for (int i = 0; i < 30; i++)
            push_vector($urandom_range(1, 3), used);
        drain_all();

        // Random phases over several curvature settings, with and without gaps.
        curv_list[0] = 16'd1;
        curv_list[1] = 16'd4096;
        curv_list[2] = 16'hFFFF;
        curv_list[3] = 16'($urandom_range(1, 8191));
        curv_list[4] = 16'($urandom);
        curv_list[5] = 16'd0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_curvature(curv_list[ph]);
            idle_on = (ph % 3) != 2;
            push_random(80);
            drain_all();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
